// File: rtl/wtsp_pkg.sv
// Shared types, constants and width helpers for the world-to-screen projection block.
package wtsp_pkg;

    localparam int LANE_W       = 16;
    localparam int ROW_W        = 64;
    localparam int SCREEN_W     = 32;
    localparam int SIZE_W       = 16;
    localparam int COORD_PORT_W = 24;
    localparam int COORD_MAX_W  = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int FRAC_SHIFT   = 12;
    localparam int TRANS_SHIFT  = 20;
    localparam int CONST_SHIFT  = 8;
    localparam int PIX_SCALE_SH = 3;
    localparam int B_W          = SIZE_W + PIX_SCALE_SH;
    localparam int Q_W          = 22;
    localparam int PIX_W        = 20;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [Q_W-1:0] PIX_CAP     = 22'd1048576;
    localparam logic [Q_W-1:0] PIX_POS_MAX = 22'd524287;
    localparam logic [Q_W-1:0] PIX_NEG_MAG = 22'd524288;
    localparam logic [FRAC_SHIFT-1:0] ROUND_HALF = 12'd2048;
    localparam logic [10:0] NEAR_W_Q20 = 11'd1049;

    localparam logic [ROW_W-1:0]    RST_VIEW_X = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0]    RST_VIEW_Y = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0]    RST_VIEW_Z = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0]    RST_PROJ_X = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0]    RST_PROJ_Y = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0]    RST_PROJ_W = 64'h1000_0000_0000_0000;
    localparam logic [SCREEN_W-1:0] RST_SCREEN = 32'h0438_0780;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEW_X = 3'd0,
        CFG_VIEW_Y = 3'd1,
        CFG_VIEW_Z = 3'd2,
        CFG_PROJ_X = 3'd3,
        CFG_PROJ_Y = 3'd4,
        CFG_PROJ_W = 3'd5,
        CFG_SCREEN = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0] view_x;
        logic [ROW_W-1:0] view_y;
        logic [ROW_W-1:0] view_z;
        logic [ROW_W-1:0] proj_x;
        logic [ROW_W-1:0] proj_y;
        logic [ROW_W-1:0] proj_w;
    } t_xform_cfg;

    function automatic logic [LANE_W-1:0] lane16(input logic [ROW_W-1:0] row, input int k);
        return row[LANE_W*k +: LANE_W];
    endfunction

    function automatic int view_w(input int coord_w, input int coef_w);
        int prod_w;
        int trn_w;
        prod_w = coord_w + coef_w;
        trn_w  = LANE_W + TRANS_SHIFT;
        return ((prod_w > trn_w) ? prod_w : trn_w) + 3 - FRAC_SHIFT;
    endfunction

    function automatic int clip_w(input int coord_w, input int coef_w);
        return view_w(coord_w, coef_w) + coef_w + 3;
    endfunction

endpackage

// File: rtl/wtsp_front.sv
// Front end: view transform and clip transform pipeline, near-plane classification.
module wtsp_front #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 16,
    parameter int CLIP_W      = 58
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_acc,
    input  logic [wtsp_pkg::COORD_PORT_W-1:0]    i_world_x,
    input  logic [wtsp_pkg::COORD_PORT_W-1:0]    i_world_y,
    input  logic [wtsp_pkg::COORD_PORT_W-1:0]    i_world_z,
    input  wtsp_pkg::t_xform_cfg                 i_cfg,
    output logic                                 o_valid,
    output logic signed [CLIP_W:0]               o_ax,
    output logic signed [CLIP_W:0]               o_ay,
    output logic signed [CLIP_W-1:0]             o_w,
    output logic                                 o_front
);
    import wtsp_pkg::*;

    localparam int PROD_W  = COORD_WIDTH + COEF_WIDTH;
    localparam int VIEW_W  = view_w(COORD_WIDTH, COEF_WIDTH);
    localparam int VSUM_W  = VIEW_W + FRAC_SHIFT;
    localparam int CPROD_W = VIEW_W + COEF_WIDTH;
    localparam int NSTG    = 5;

    logic [ROW_W-1:0] view_rows [3];
    logic [ROW_W-1:0] proj_rows [3];

    logic [COORD_MAX_W-1:0]          ext [3];
    logic signed [COORD_WIDTH-1:0]   r_p [3];
    logic signed [PROD_W-1:0]        r_vprod [3][3];
    logic signed [VSUM_W-1:0]        vsum [3];
    logic signed [VSUM_W-1:0]        vshift [3];
    logic signed [VIEW_W-1:0]        r_v [3];
    logic signed [CPROD_W-1:0]       r_cprod [3][3];
    logic signed [CLIP_W-1:0]        csum [3];
    logic signed [CLIP_W-1:0]        r_clip [3];
    logic [NSTG-1:0]                 r_vld;

    assign view_rows[0] = i_cfg.view_x;
    assign view_rows[1] = i_cfg.view_y;
    assign view_rows[2] = i_cfg.view_z;
    assign proj_rows[0] = i_cfg.proj_x;
    assign proj_rows[1] = i_cfg.proj_y;
    assign proj_rows[2] = i_cfg.proj_w;

    assign ext[0] = COORD_MAX_W'(i_world_x);
    assign ext[1] = COORD_MAX_W'(i_world_y);
    assign ext[2] = COORD_MAX_W'(i_world_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[NSTG-2:0], i_acc};
            o_valid <= r_vld[NSTG-1];
        end
    end

    always_comb begin
        logic [LANE_W-1:0] lw;
        logic [LANE_W-1:0] l3;
        for (int r = 0; r < 3; r++) begin
            lw = view_rows[r][ROW_W-1 -: LANE_W];
            vsum[r] = VSUM_W'(r_vprod[r][0]) + VSUM_W'(r_vprod[r][1])
                    + VSUM_W'(r_vprod[r][2])
                    + (VSUM_W'($signed(lw)) <<< TRANS_SHIFT)
                    + VSUM_W'(ROUND_HALF);
            vshift[r] = vsum[r] >>> FRAC_SHIFT;
            l3 = lane16(proj_rows[r], 3);
            csum[r] = CLIP_W'(r_cprod[r][0]) + CLIP_W'(r_cprod[r][1])
                    + CLIP_W'(r_cprod[r][2])
                    + (CLIP_W'($signed(l3[COEF_WIDTH-1:0])) <<< CONST_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [LANE_W-1:0] lv;
        logic [LANE_W-1:0] lp;
        if (i_acc) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= $signed(ext[k][COORD_WIDTH-1:0]);
            end
        end
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                lv = lane16(view_rows[r], k);
                lp = lane16(proj_rows[r], k);
                r_vprod[r][k] <= PROD_W'(r_p[k] * $signed(lv[COEF_WIDTH-1:0]));
                r_cprod[r][k] <= CPROD_W'(r_v[k] * $signed(lp[COEF_WIDTH-1:0]));
            end
            r_v[r]    <= vshift[r][VIEW_W-1:0];
            r_clip[r] <= csum[r];
        end
        // clip rows: 0 is x, 1 is y, 2 is w
        o_ax    <= (CLIP_W+1)'(r_clip[0]) + (CLIP_W+1)'(r_clip[2]);
        o_ay    <= (CLIP_W+1)'(r_clip[2]) - (CLIP_W+1)'(r_clip[1]);
        o_w     <= r_clip[2];
        o_front <= r_clip[2] >= $signed(CLIP_W'(NEAR_W_Q20));
    end

endmodule

// File: rtl/wtsp_queue.sv
// Short request queue between the front end and the back end.
module wtsp_queue #(
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);
    import wtsp_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [DATA_W-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              pop;

    // the back end never stalls: drain whenever something is held
    assign pop    = r_count != '0;
    assign o_full = r_count == CNT_W'(QUEUE_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_data;
        end
        if (pop) begin
            o_data <= mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= pop;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

endmodule

// File: rtl/wtsp_div.sv
// Pipelined restoring divider: one quotient bit per stage, with overflow flag.
module wtsp_div #(
    parameter int NUM_W  = 80,
    parameter int DEN_W  = 58,
    parameter int SIDE_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [NUM_W-1:0]          i_num,
    input  logic [DEN_W-1:0]          i_den,
    input  logic [SIDE_W-1:0]         i_side,
    output logic                      o_valid,
    output logic [wtsp_pkg::Q_W-1:0]  o_quot,
    output logic                      o_over,
    output logic [SIDE_W-1:0]         o_side
);
    import wtsp_pkg::*;

    localparam int HI_W  = NUM_W - Q_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0]  r_rem  [Q_W+1];
    logic [Q_W-1:0]    r_low  [Q_W+1];
    logic [Q_W-1:0]    r_q    [Q_W+1];
    logic [DEN_W-1:0]  r_den  [Q_W+1];
    logic              r_over [Q_W+1];
    logic [SIDE_W-1:0] r_side [Q_W+1];
    logic [Q_W:0]      r_vld;

    logic [HI_W-1:0]   hi;
    logic [CMP_W-1:0]  hi_ext;

    assign hi     = i_num[NUM_W-1:Q_W];
    assign hi_ext = CMP_W'(hi);

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= hi_ext[DEN_W-1:0];
        r_low[0]  <= i_num[Q_W-1:0];
        r_q[0]    <= '0;
        r_den[0]  <= i_den;
        // quotient would not fit: result is capped later
        r_over[0] <= hi_ext >= CMP_W'(i_den);
        r_side[0] <= i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[Q_W-1:0], i_valid};
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W:0] rem2;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb begin
            rem2 = {r_rem[k], r_low[k][Q_W-1]};
            diff = rem2 - {1'b0, r_den[k]};
            ge   = rem2 >= {1'b0, r_den[k]};
        end

        always_ff @(posedge i_clk) begin
            r_rem[k+1]  <= ge ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
            r_low[k+1]  <= {r_low[k][Q_W-2:0], 1'b0};
            r_q[k+1]    <= {r_q[k][Q_W-2:0], ge};
            r_den[k+1]  <= r_den[k];
            r_over[k+1] <= r_over[k];
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_valid = r_vld[Q_W];
    assign o_quot  = r_q[Q_W];
    assign o_over  = r_over[Q_W];
    assign o_side  = r_side[Q_W];

endmodule

// File: rtl/wtsp_back.sv
// Back end: magnitude, scale by screen size, divide by w, round, saturate, bounds test.
module wtsp_back #(
    parameter int CLIP_W = 58
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [CLIP_W:0]                i_ax,
    input  logic signed [CLIP_W:0]                i_ay,
    input  logic signed [CLIP_W-1:0]              i_w,
    input  logic                                  i_front,
    input  logic [wtsp_pkg::SCREEN_W-1:0]         i_screen,
    output logic                                  o_valid,
    output logic signed [wtsp_pkg::PIX_W-1:0]     o_screen_x,
    output logic signed [wtsp_pkg::PIX_W-1:0]     o_screen_y,
    output logic                                  o_in_front,
    output logic                                  o_on_screen
);
    import wtsp_pkg::*;

    localparam int A_W   = CLIP_W + 1;
    localparam int LO_W  = (A_W + 1) / 2;
    localparam int HI_W  = A_W - LO_W;
    localparam int N_W   = A_W + B_W;
    localparam int NUM_W = N_W + 1;

    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic signed [A_W-1:0] w2;

    // magnitude stage
    logic [A_W-1:0]    r_magx, r_magy;
    logic              r_negx, r_negy, r_on0, r_front0, r_vld0;
    logic [B_W-1:0]    r_bx, r_by;
    logic [CLIP_W-1:0] r_w0;
    // partial product stage
    logic [LO_W+B_W-1:0] r_plx, r_ply;
    logic [HI_W+B_W-1:0] r_phx, r_phy;
    logic                r_negx1, r_negy1, r_on1, r_front1, r_vld1;
    logic [CLIP_W-1:0]   r_w1;
    // product stage
    logic [N_W-1:0]    r_nx, r_ny;
    logic              r_negx2, r_negy2, r_on2, r_front2, r_vld2;
    logic [CLIP_W-1:0] r_w2;

    logic             dx_vld, dy_vld, dx_over, dy_over;
    logic [Q_W-1:0]   dx_q, dy_q;
    logic [2:0]       dx_side;
    logic [0:0]       dy_side;

    logic [Q_W:0]     rx_sum, ry_sum;
    logic [Q_W-1:0]   qx, qy;
    logic [PIX_W-1:0] px, py;

    assign width  = i_screen[SIZE_W-1:0];
    assign height = i_screen[SCREEN_W-1:SIZE_W];
    assign w2     = $signed({i_w, 1'b0});

    always_ff @(posedge i_clk) begin
        r_magx   <= i_ax[A_W-1] ? A_W'(-i_ax) : A_W'(i_ax);
        r_magy   <= i_ay[A_W-1] ? A_W'(-i_ay) : A_W'(i_ay);
        r_negx   <= i_ax[A_W-1];
        r_negy   <= i_ay[A_W-1];
        // a zero screen dimension counts as inside on that axis
        r_on0    <= ((width == '0) || (!i_ax[A_W-1] && i_ax <= w2))
                 && ((height == '0) || (!i_ay[A_W-1] && i_ay <= w2));
        r_front0 <= i_front;
        r_bx     <= {width, {PIX_SCALE_SH{1'b0}}};
        r_by     <= {height, {PIX_SCALE_SH{1'b0}}};
        r_w0     <= i_w;

        r_plx    <= (LO_W+B_W)'(r_magx[LO_W-1:0] * r_bx);
        r_phx    <= (HI_W+B_W)'(r_magx[A_W-1:LO_W] * r_bx);
        r_ply    <= (LO_W+B_W)'(r_magy[LO_W-1:0] * r_by);
        r_phy    <= (HI_W+B_W)'(r_magy[A_W-1:LO_W] * r_by);
        r_negx1  <= r_negx;
        r_negy1  <= r_negy;
        r_on1    <= r_on0;
        r_front1 <= r_front0;
        r_w1     <= r_w0;

        r_nx     <= (N_W'(r_phx) << LO_W) + N_W'(r_plx);
        r_ny     <= (N_W'(r_phy) << LO_W) + N_W'(r_ply);
        r_negx2  <= r_negx1;
        r_negy2  <= r_negy1;
        r_on2    <= r_on1;
        r_front2 <= r_front1;
        r_w2     <= r_w1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld0 <= i_valid;
            r_vld1 <= r_vld0;
            r_vld2 <= r_vld1;
        end
    end

    // dividers produce floor(2N/w); half of that plus one half rounds N/w
    wtsp_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (CLIP_W),
        .SIDE_W (3)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld2),
        .i_num   ({r_nx, 1'b0}),
        .i_den   (r_w2),
        .i_side  ({r_front2, r_on2, r_negx2}),
        .o_valid (dx_vld),
        .o_quot  (dx_q),
        .o_over  (dx_over),
        .o_side  (dx_side)
    );

    wtsp_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (CLIP_W),
        .SIDE_W (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld2),
        .i_num   ({r_ny, 1'b0}),
        .i_den   (r_w2),
        .i_side  (r_negy2),
        .o_valid (dy_vld),
        .o_quot  (dy_q),
        .o_over  (dy_over),
        .o_side  (dy_side)
    );

    always_comb begin
        rx_sum = (Q_W+1)'(dx_q) + (Q_W+1)'(1);
        ry_sum = (Q_W+1)'(dy_q) + (Q_W+1)'(1);
        qx = (dx_over || rx_sum[Q_W:1] > PIX_CAP) ? PIX_CAP : rx_sum[Q_W:1];
        qy = (dy_over || ry_sum[Q_W:1] > PIX_CAP) ? PIX_CAP : ry_sum[Q_W:1];
        if (dx_side[0]) begin
            px = (qx > PIX_NEG_MAG) ? PIX_NEG_MAG[PIX_W-1:0] : PIX_W'(-qx[PIX_W-1:0]);
        end else begin
            px = (qx > PIX_POS_MAX) ? PIX_POS_MAX[PIX_W-1:0] : qx[PIX_W-1:0];
        end
        if (dy_side[0]) begin
            py = (qy > PIX_NEG_MAG) ? PIX_NEG_MAG[PIX_W-1:0] : PIX_W'(-qy[PIX_W-1:0]);
        end else begin
            py = (qy > PIX_POS_MAX) ? PIX_POS_MAX[PIX_W-1:0] : qy[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_screen_x  <= dx_side[2] ? $signed(px) : '0;
        o_screen_y  <= dx_side[2] ? $signed(py) : '0;
        o_in_front  <= dx_side[2];
        o_on_screen <= dx_side[2] && dx_side[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= dx_vld && dy_vld;
        end
    end

endmodule

// File: rtl/world_to_screen_projection.sv
// Top level of the world-to-screen perspective projection block.
//
// Usage:
//   Requests: drive i_world_x/y/z (signed Q16.8) with start; a request is taken
//   at a rising edge where start is high and busy is low. busy stays low in
//   normal use, so one request may be issued every cycle.
//   Results: o_valid pulses for one cycle with o_screen_x/y (signed Q16.4),
//   o_in_front and o_on_screen; there is no back-pressure, results leave as
//   they finish, one per request, in request order.
//   Pipeline: a request passes the transform stages, the request queue, the
//   scaling stages and the 22-stage divider pipeline; throughput one request
//   per cycle while busy is low.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
//   write only while no request is in flight. Unknown indexes are ignored.
//   Reset: synchronous active-low i_rst_n restores the identity view and
//   projection and a 1920x1080 screen, and drops everything in flight.
module world_to_screen_projection #(
    parameter int COORD_WIDTH = 24,
    parameter int COEF_WIDTH  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [wtsp_pkg::COORD_PORT_W-1:0] i_world_x,
    input  logic signed [wtsp_pkg::COORD_PORT_W-1:0] i_world_y,
    input  logic signed [wtsp_pkg::COORD_PORT_W-1:0] i_world_z,
    output logic                                  o_valid,
    output logic signed [wtsp_pkg::PIX_W-1:0]     o_screen_x,
    output logic signed [wtsp_pkg::PIX_W-1:0]     o_screen_y,
    output logic                                  o_in_front,
    output logic                                  o_on_screen,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [wtsp_pkg::ROW_W-1:0]            i_cfg_data
);
    import wtsp_pkg::*;

    localparam int CLIP_W = clip_w(COORD_WIDTH, COEF_WIDTH);
    localparam int A_W    = CLIP_W + 1;
    localparam int QD_W   = 2 * A_W + CLIP_W + 1;

    t_xform_cfg          r_cfg;
    logic [SCREEN_W-1:0] r_screen;

    logic                 acc;
    logic                 f_valid, f_front;
    logic signed [A_W-1:0]    f_ax, f_ay;
    logic signed [CLIP_W-1:0] f_w;
    logic                 q_full, q_valid;
    logic [QD_W-1:0]      q_data;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign acc         = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_x <= RST_VIEW_X;
            r_cfg.view_y <= RST_VIEW_Y;
            r_cfg.view_z <= RST_VIEW_Z;
            r_cfg.proj_x <= RST_PROJ_X;
            r_cfg.proj_y <= RST_PROJ_Y;
            r_cfg.proj_w <= RST_PROJ_W;
            r_screen     <= RST_SCREEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VIEW_X: r_cfg.view_x <= i_cfg_data;
                CFG_VIEW_Y: r_cfg.view_y <= i_cfg_data;
                CFG_VIEW_Z: r_cfg.view_z <= i_cfg_data;
                CFG_PROJ_X: r_cfg.proj_x <= i_cfg_data;
                CFG_PROJ_Y: r_cfg.proj_y <= i_cfg_data;
                CFG_PROJ_W: r_cfg.proj_w <= i_cfg_data;
                CFG_SCREEN: r_screen     <= i_cfg_data[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    wtsp_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH),
        .CLIP_W      (CLIP_W)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_world_x (i_world_x),
        .i_world_y (i_world_y),
        .i_world_z (i_world_z),
        .i_cfg     (r_cfg),
        .o_valid   (f_valid),
        .o_ax      (f_ax),
        .o_ay      (f_ay),
        .o_w       (f_w),
        .o_front   (f_front)
    );

    wtsp_queue #(
        .DATA_W (QD_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_front, f_w, f_ay, f_ax}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    wtsp_back #(
        .CLIP_W (CLIP_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_ax        ($signed(q_data[A_W-1:0])),
        .i_ay        ($signed(q_data[2*A_W-1:A_W])),
        .i_w         ($signed(q_data[2*A_W+CLIP_W-1:2*A_W])),
        .i_front     (q_data[QD_W-1]),
        .i_screen    (r_screen),
        .o_valid     (o_valid),
        .o_screen_x  (o_screen_x),
        .o_screen_y  (o_screen_y),
        .o_in_front  (o_in_front),
        .o_on_screen (o_on_screen)
    );

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_valid |-> !q_full)
        else $error("request queue overflow");

    a_behind_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_front) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("point behind viewer has nonzero pixel");

    a_on_needs_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_on_screen) |-> o_in_front)
        else $error("on_screen set for point behind viewer");
`endif

endmodule
